FILE: rtl/core/delimited_record_splitter_macros.svh
// Assertion macros for the delimited record splitter.
// Bodies refer to clk and arst_n of the including module; no other dependencies.
`ifndef DELIMITED_RECORD_SPLITTER_MACROS_SVH
`define DELIMITED_RECORD_SPLITTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define DRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/drs_pkg.sv
// Shared types and codes for the delimited record splitter.
// No dependencies.
`timescale 1ns / 1ps

package drs_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int DELIM_W   = 64;
	localparam int DLEN_W    = 4;
	localparam int RLEN_W    = 16;

	typedef logic [7:0] byte_t;

	typedef enum logic {
		OP_DATA  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic {
		MODE_DELIM = 1'b0,
		MODE_FIXED = 1'b1
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE        = 3'd0,
		CFG_DELIM_BYTES = 3'd1,
		CFG_DELIM_LEN   = 3'd2,
		CFG_RECORD_LEN  = 3'd3
	} cfg_idx_t;

	typedef struct packed {
		byte_t out_byte;
		logic  byte_valid;
		logic  record_end;
	} res_t;

endpackage

FILE: rtl/core/delimited_record_splitter.sv
// Delimited record splitter top level: splits a byte stream into records.
// Depends on drs_pkg and delimited_record_splitter_macros.svh.
//
//   channel | handshake               | payload
//   --------+-------------------------+---------------------------------------
//   in      | in_valid / in_stall     | op, data_byte
//   out     | out_valid / out_stall   | out_byte, byte_valid, record_end
//   cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One beat per cycle sustained on the input while in_stall is low; a clear
// beat or a byte that only fills the match window gives no output beat. A beat
// is registered into stage one, processed against the window in one pass, and
// its result moves into the output register once that has a free slot.
// The window update (write, compare, shift) is combinational.
// Reset clears the registers to mode 0, newline delimiter of length 1, record
// length 1, empty window and zero byte count; no clearing pass is needed.
// Stage one keeps taking beats while a result waits in the output register;
// in_stall rises only when stage one holds a beat with a result to deliver
// and the output register is full and stalled.
`timescale 1ns / 1ps
`include "delimited_record_splitter_macros.svh"

module delimited_record_splitter
	import drs_pkg::*;
#(
	parameter int MAX_DELIM_LEN = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input beats
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 op,
	input  logic [7:0]           data_byte,
	// output beats
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 byte_valid,
	output logic                 record_end,
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DELIM_W-1:0]   cfg_data
);

	// Fill count must hold 0..MAX_DELIM_LEN
	localparam int FILL_W = $clog2(MAX_DELIM_LEN + 1);

	// Configuration registers
	mode_t              mode_q;
	logic [DELIM_W-1:0] delim_q;
	logic [DLEN_W-1:0]  dlen_q;
	logic [RLEN_W-1:0]  rlen_q;

	// Splitter state
	byte_t              win_q [MAX_DELIM_LEN];
	logic [FILL_W-1:0]  fill_q;
	logic [RLEN_W-1:0]  cnt_q;

	// Stage one: registered input beat
	logic               valid_s1;
	op_t                op_s1;
	byte_t              byte_s1;

	// Output register
	logic               out_valid_q;
	res_t               res_q;

	// Processing of the stage-one beat
	logic [DLEN_W-1:0]  eff_len_w;
	logic [FILL_W-1:0]  eff_len;
	logic [FILL_W-1:0]  fill_g;
	logic [FILL_W-1:0]  fill_n;
	logic               full;
	logic               hit;
	byte_t              win_new   [MAX_DELIM_LEN];
	byte_t              win_shift [MAX_DELIM_LEN];
	logic [RLEN_W-1:0]  rlen_eff;
	logic [RLEN_W-1:0]  cnt_inc;
	logic               rec_done;

	byte_t              win_d [MAX_DELIM_LEN];
	logic [FILL_W-1:0]  fill_d;
	logic [RLEN_W-1:0]  cnt_d;
	logic               has_res;
	res_t               res_d;

	// Handshake
	logic               out_free;
	logic               s1_go;
	logic               in_acc;
	logic               cfg_wr;
	logic               cfg_clear;

	// Window compare, shift and byte count for the beat in stage one
	always_comb begin
		// effective delimiter length: zero means one, saturate at the window depth
		eff_len_w = dlen_q;
		if (dlen_q == '0) begin
			eff_len_w = DLEN_W'(1);
		end else if (dlen_q > DLEN_W'(MAX_DELIM_LEN)) begin
			eff_len_w = DLEN_W'(MAX_DELIM_LEN);
		end
		eff_len = eff_len_w[FILL_W-1:0];

		// keep the write slot inside the delimiter length
		fill_g = (fill_q >= eff_len) ? (eff_len - 1'b1) : fill_q;
		fill_n = fill_g + 1'b1;
		full   = (fill_n >= eff_len);

		for (int i = 0; i < MAX_DELIM_LEN; i++) begin
			win_new[i] = (fill_g == FILL_W'(i)) ? byte_s1 : win_q[i];
		end

		hit = 1'b1;
		for (int i = 0; i < MAX_DELIM_LEN; i++) begin
			if ((FILL_W'(i) < eff_len) && (win_new[i] != delim_q[8*i +: 8])) begin
				hit = 1'b0;
			end
		end

		// drop the oldest byte, zero-fill the top
		for (int i = 0; i < MAX_DELIM_LEN; i++) begin
			win_shift[i] = (i == MAX_DELIM_LEN - 1) ? '0 : win_new[(i + 1) % MAX_DELIM_LEN];
		end

		// fixed-length count; a zero length ends every record, so does wrap
		rlen_eff = (rlen_q == '0) ? RLEN_W'(1) : rlen_q;
		cnt_inc  = cnt_q + 1'b1;
		rec_done = (cnt_inc >= rlen_eff) || (cnt_inc == '0);

		// next state and result
		win_d   = win_q;
		fill_d  = fill_q;
		cnt_d   = cnt_q;
		has_res = 1'b0;
		res_d   = '0;

		if (op_s1 == OP_CLEAR) begin
			for (int i = 0; i < MAX_DELIM_LEN; i++) begin
				win_d[i] = '0;
			end
			fill_d = '0;
			cnt_d  = '0;
		end else if (mode_q == MODE_FIXED) begin
			has_res          = 1'b1;
			res_d.out_byte   = byte_s1;
			res_d.byte_valid = 1'b1;
			res_d.record_end = rec_done;
			cnt_d            = rec_done ? '0 : cnt_inc;
		end else if (!full) begin
			// still could be the start of a delimiter: hold it
			win_d  = win_new;
			fill_d = fill_n;
		end else if (hit) begin
			// delimiter complete: emit the marker, drop the delimiter
			has_res          = 1'b1;
			res_d.record_end = 1'b1;
			for (int i = 0; i < MAX_DELIM_LEN; i++) begin
				win_d[i] = '0;
			end
			fill_d = '0;
		end else begin
			// no match possible from the oldest byte: release it
			has_res          = 1'b1;
			res_d.out_byte   = win_new[0];
			res_d.byte_valid = 1'b1;
			win_d            = win_shift;
			fill_d           = fill_n - 1'b1;
		end
	end

	// A stage-one beat moves on when its result has a free slot, or needs none
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_go     = valid_s1 && (!has_res || out_free);
	assign in_stall  = valid_s1 && !s1_go;
	assign in_acc    = in_valid && !in_stall;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	// mode or delimiter length changes drop held bytes and the count
	assign cfg_clear = cfg_wr &&
		((cfg_idx_t'(cfg_index) == CFG_MODE) || (cfg_idx_t'(cfg_index) == CFG_DELIM_LEN));

	// Control and splitter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_DELIM;
			delim_q     <= DELIM_W'(10);
			dlen_q      <= DLEN_W'(1);
			rlen_q      <= RLEN_W'(1);
			for (int i = 0; i < MAX_DELIM_LEN; i++) begin
				win_q[i] <= '0;
			end
			fill_q      <= '0;
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// stage one: load on accept, empty once processed
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end

			// output register: load a new result, else drop once taken
			if (s1_go && has_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (s1_go) begin
				win_q  <= win_d;
				fill_q <= fill_d;
				cnt_q  <= cnt_d;
			end

			if (cfg_wr) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_MODE: begin
						mode_q <= mode_t'(cfg_data[0]);
					end
					CFG_DELIM_BYTES: begin
						delim_q <= cfg_data;
					end
					CFG_DELIM_LEN: begin
						dlen_q <= cfg_data[DLEN_W-1:0];
					end
					CFG_RECORD_LEN: begin
						rlen_q <= cfg_data[RLEN_W-1:0];
					end
					default: begin
						// unlisted index: ignore the write
					end
				endcase
			end

			if (cfg_clear) begin
				for (int i = 0; i < MAX_DELIM_LEN; i++) begin
					win_q[i] <= '0;
				end
				fill_q <= '0;
				cnt_q  <= '0;
			end
		end
	end

	// Payload registers: no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= op_t'(op);
			byte_s1 <= data_byte;
		end
		if (s1_go && has_res) begin
			res_q <= res_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = res_q.out_byte;
	assign byte_valid = res_q.byte_valid;
	assign record_end = res_q.record_end;

	// Window never holds a full delimiter between beats
	`DRS_ASSERT_NOW(a_fill_below_len, 1'b1, fill_q < eff_len, "window fill reached delimiter length")
	// A beat without a byte is always a bare record-end marker
	`DRS_ASSERT_NOW(a_marker_shape, out_valid_q && !res_q.byte_valid, res_q.record_end && (res_q.out_byte == '0), "malformed record-end marker")
	// A completed delimiter empties the window
	`DRS_ASSERT_NEXT(a_match_clears, s1_go && (op_s1 == OP_DATA) && (mode_q == MODE_DELIM) && full && hit, fill_q == '0, "window not cleared after delimiter match")
	// A fixed-length record end restarts the count
	`DRS_ASSERT_NEXT(a_count_restarts, s1_go && (op_s1 == OP_DATA) && (mode_q == MODE_FIXED) && rec_done, cnt_q == '0, "byte count not restarted at record end")

endmodule
